>>> rtl/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

    localparam int MinYearDef = 1601;
    localparam int MaxYearDef = 9999;

    localparam int W_OP   = 3;
    localparam int W_DAY  = 5;
    localparam int W_MON  = 4;
    localparam int W_YEAR = 14;
    localparam int W_CNT  = 16;
    localparam int W_NUM  = 22;
    localparam int W_ST   = 2;
    localparam int W_SER  = 23;

    localparam logic [W_OP-1:0] OP_VALIDATE = 3'd0;
    localparam logic [W_OP-1:0] OP_ADD      = 3'd1;
    localparam logic [W_OP-1:0] OP_SUB      = 3'd2;
    localparam logic [W_OP-1:0] OP_DIFF     = 3'd3;
    localparam logic [W_OP-1:0] OP_WEEKDAY  = 3'd4;

    localparam logic [W_ST-1:0] ST_OK       = 2'd0;
    localparam logic [W_ST-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [W_ST-1:0] ST_ORDER    = 2'd2;
    localparam logic [W_ST-1:0] ST_RANGE    = 2'd3;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Year strides of the Gregorian cycle and their lengths in days.
    localparam logic [8:0]  STRIDE_YEARS [4] = '{9'd400, 9'd100, 9'd4, 9'd1};
    localparam logic [17:0] STRIDE_DAYS  [4] = '{18'd146097, 18'd36524, 18'd1461, 18'd365};

    typedef struct packed {
        logic valid;
        logic leap;
    } t_date_info;

    function automatic logic [4:0] month_days(input logic [W_MON-1:0] mon, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        if (mon >= 4'd1 && mon <= 4'd12) begin
            len = MONTH_LEN[mon - 4'd1];
        end
        if (mon == 4'd2 && leap) begin
            len = 5'd29;
        end
        return len;
    endfunction

    // The low bits of year * 5243 are small exactly when the year is a multiple of 100,
    // and the high bits give the year divided by 100.
    function automatic logic is_leap(input logic [W_YEAR-1:0] year);
        logic [26:0] prod;
        logic        is100;
        logic        is400;
        prod  = 27'(year) * 27'd5243;
        is100 = (prod[18:11] == 8'd0);
        is400 = is100 && (prod[20:19] == 2'b00);
        return ((year[1:0] == 2'b00) && !is100) || is400;
    endfunction

endpackage

>>> rtl/gda_alu.sv
`timescale 1ns / 1ps

module gda_alu (
    input  logic [gda_pkg::W_SER-1:0] i_a,
    input  logic [gda_pkg::W_SER-1:0] i_b,
    input  logic                      i_sub,
    output logic [gda_pkg::W_SER-1:0] o_sum,
    output logic                      o_ge
);
    import gda_pkg::*;

    logic [W_SER:0] wide;

    always_comb begin
        if (i_sub) begin
            wide = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            wide = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_sum = wide[W_SER-1:0];
    assign o_ge  = !wide[W_SER];

endmodule

>>> rtl/gda_date_check.sv
`timescale 1ns / 1ps

module gda_date_check #(
    parameter int MIN_YEAR = gda_pkg::MinYearDef,
    parameter int MAX_YEAR = gda_pkg::MaxYearDef
) (
    input  logic [gda_pkg::W_DAY-1:0]  i_day,
    input  logic [gda_pkg::W_MON-1:0]  i_month,
    input  logic [gda_pkg::W_YEAR-1:0] i_year,
    output gda_pkg::t_date_info        o_info
);
    import gda_pkg::*;

    logic leap;
    logic year_ok;
    logic month_ok;
    logic day_ok;

    always_comb begin
        leap     = is_leap(i_year);
        year_ok  = (i_year >= W_YEAR'(MIN_YEAR)) && (i_year <= W_YEAR'(MAX_YEAR));
        month_ok = (i_month >= 4'd1) && (i_month <= 4'd12);
        day_ok   = (i_day != 5'd0) && (i_day <= month_days(i_month, leap));
        o_info.valid = year_ok && month_ok && day_ok;
        o_info.leap  = leap;
    end

endmodule

>>> rtl/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// One request at a time: busy is high from the accepted start until the result strobe.
// Validate or a bad date goes from the check straight to the result. Add, subtract, difference
// and weekday run the year and month stepping loops, and weekday then the modulo-7 loop, all of
// which share one 23-bit adder; the last busy cycle carries the result strobe.
// A new request is taken the cycle after the result strobe.
// Synchronous active-low reset returns the sequencer to idle; the receiver cannot stall.

module gregorian_date_arithmetic #(
    parameter int MIN_YEAR = gda_pkg::MinYearDef,
    parameter int MAX_YEAR = gda_pkg::MaxYearDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [gda_pkg::W_OP-1:0]   i_opcode,
    input  logic [gda_pkg::W_DAY-1:0]  i_day_a,
    input  logic [gda_pkg::W_MON-1:0]  i_month_a,
    input  logic [gda_pkg::W_YEAR-1:0] i_year_a,
    input  logic [gda_pkg::W_DAY-1:0]  i_day_b,
    input  logic [gda_pkg::W_MON-1:0]  i_month_b,
    input  logic [gda_pkg::W_YEAR-1:0] i_year_b,
    input  logic [gda_pkg::W_CNT-1:0]  i_day_count,
    output logic                      o_done,
    output logic [gda_pkg::W_DAY-1:0]  o_result_day,
    output logic [gda_pkg::W_MON-1:0]  o_result_month,
    output logic [gda_pkg::W_YEAR-1:0] o_result_year,
    output logic [gda_pkg::W_NUM-1:0]  o_result_number,
    output logic                      o_date_valid,
    output logic [gda_pkg::W_ST-1:0]   o_status
);
    import gda_pkg::*;

    localparam int LoYears  = MIN_YEAR - 1;
    localparam int HiYears  = MAX_YEAR;
    localparam int SerLoInt = 365 * LoYears + LoYears / 4 - LoYears / 100 + LoYears / 400;
    localparam int SerHiInt = 365 * HiYears + HiYears / 4 - HiYears / 100 + HiYears / 400;
    localparam logic [W_SER-1:0] SER_LO = W_SER'(SerLoInt);
    localparam logic [W_SER-1:0] SER_HI = W_SER'(SerHiInt);
    localparam logic [W_SER-1:0] SEVEN  = W_SER'(7);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_YFWD  = 11'b000_0000_0100,
        S_MFWD  = 11'b000_0000_1000,
        S_ADJ   = 11'b000_0001_0000,
        S_BOUND = 11'b000_0010_0000,
        S_DIFF  = 11'b000_0100_0000,
        S_YREV  = 11'b000_1000_0000,
        S_MREV  = 11'b001_0000_0000,
        S_MOD7  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [W_OP-1:0]   r_op, n_op;
    logic [W_DAY-1:0]  r_day_a, n_day_a, r_day_b, n_day_b;
    logic [W_MON-1:0]  r_month_a, n_month_a, r_month_b, n_month_b;
    logic [W_YEAR-1:0] r_year_a, n_year_a, r_year_b, n_year_b;
    logic [W_CNT-1:0]  r_count, n_count;

    logic              r_second, n_second;
    logic [1:0]        r_phase, n_phase;
    logic [1:0]        r_n100, n_n100;
    logic [4:0]        r_n4, n_n4;
    logic [1:0]        r_n1, n_n1;
    logic [4:0]        r_k, n_k;
    logic [W_MON-1:0]  r_mon, n_mon;
    logic              r_leap, n_leap;
    logic [W_SER-1:0]  r_ser, n_ser;
    logic [W_SER-1:0]  r_sa, n_sa;
    logic [W_YEAR-1:0] r_yrem, n_yrem;

    logic              r_va, n_va;
    logic [W_DAY-1:0]  r_rd, n_rd;
    logic [W_MON-1:0]  r_rm, n_rm;
    logic [W_YEAR-1:0] r_ry, n_ry;
    logic [W_NUM-1:0]  r_rn, n_rn;
    logic [W_ST-1:0]   r_st, n_st;

    t_date_info        info_a;
    t_date_info        info_b;

    logic [W_SER-1:0]  alu_a;
    logic [W_SER-1:0]  alu_b;
    logic              alu_sub;
    logic [W_SER-1:0]  alu_sum;
    logic              alu_ge;

    logic [8:0]        stride_y;
    logic [17:0]       stride_d;
    logic              rev_leap;
    logic              cap;
    logic [W_MON-1:0]  mon_target;
    logic [W_SER-1:0]  ser_mod;

    gda_date_check #(.MIN_YEAR(MIN_YEAR), .MAX_YEAR(MAX_YEAR)) u_check_a (
        .i_day   (r_day_a),
        .i_month (r_month_a),
        .i_year  (r_year_a),
        .o_info  (info_a)
    );

    gda_date_check #(.MIN_YEAR(MIN_YEAR), .MAX_YEAR(MAX_YEAR)) u_check_b (
        .i_day   (r_day_b),
        .i_month (r_month_b),
        .i_year  (r_year_b),
        .o_info  (info_b)
    );

    gda_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_ge  (alu_ge)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_day_a   = r_day_a;
        n_month_a = r_month_a;
        n_year_a  = r_year_a;
        n_day_b   = r_day_b;
        n_month_b = r_month_b;
        n_year_b  = r_year_b;
        n_count   = r_count;
        n_second  = r_second;
        n_phase   = r_phase;
        n_n100    = r_n100;
        n_n4      = r_n4;
        n_n1      = r_n1;
        n_k       = r_k;
        n_mon     = r_mon;
        n_leap    = r_leap;
        n_ser     = r_ser;
        n_sa      = r_sa;
        n_yrem    = r_yrem;
        n_va      = r_va;
        n_rd      = r_rd;
        n_rm      = r_rm;
        n_ry      = r_ry;
        n_rn      = r_rn;
        n_st      = r_st;

        stride_y   = STRIDE_YEARS[r_phase];
        stride_d   = STRIDE_DAYS[r_phase];
        rev_leap   = (r_n1 == 2'd3) && ((r_n4 != 5'd24) || (r_n100 == 2'd3));
        cap        = ((r_phase == 2'd1) && (r_n100 == 2'd3)) ||
                     ((r_phase == 2'd3) && (r_n1 == 2'd3));
        mon_target = r_second ? r_month_b : r_month_a;

        alu_a   = r_ser;
        alu_b   = W_SER'(stride_d);
        alu_sub = 1'b1;
        ser_mod = r_ser;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = i_opcode;
                    n_day_a   = i_day_a;
                    n_month_a = i_month_a;
                    n_year_a  = i_year_a;
                    n_day_b   = i_day_b;
                    n_month_b = i_month_b;
                    n_year_b  = i_year_b;
                    n_count   = i_day_count;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                n_va     = info_a.valid;
                n_rd     = '0;
                n_rm     = '0;
                n_ry     = '0;
                n_rn     = '0;
                n_st     = ST_OK;
                n_second = 1'b0;
                n_yrem   = r_year_a - W_YEAR'(1);
                n_ser    = W_SER'(r_day_a - W_DAY'(1));
                n_phase  = 2'd0;
                n_mon    = 4'd1;
                n_leap   = info_a.leap;
                if (r_op == OP_DIFF) begin
                    if (!info_a.valid || !info_b.valid) begin
                        n_st    = ST_BAD_DATE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_YFWD;
                    end
                end else if (!info_a.valid) begin
                    n_st    = ST_BAD_DATE;
                    n_state = S_OUT;
                end else if (r_op == OP_ADD || r_op == OP_SUB || r_op == OP_WEEKDAY) begin
                    n_state = S_YFWD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_YFWD: begin
                alu_sub = 1'b0;
                if (r_yrem >= W_YEAR'(stride_y)) begin
                    n_yrem = r_yrem - W_YEAR'(stride_y);
                    n_ser  = alu_sum;
                end else if (r_phase == 2'd3) begin
                    n_state = S_MFWD;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            S_MFWD: begin
                alu_sub = 1'b0;
                alu_b   = W_SER'(month_days(r_mon, r_leap));
                if (r_mon < mon_target) begin
                    n_ser = alu_sum;
                    n_mon = r_mon + 4'd1;
                end else if (r_op == OP_DIFF && !r_second) begin
                    n_sa     = r_ser;
                    n_second = 1'b1;
                    n_yrem   = r_year_b - W_YEAR'(1);
                    n_ser    = W_SER'(r_day_b - W_DAY'(1));
                    n_phase  = 2'd0;
                    n_mon    = 4'd1;
                    n_leap   = info_b.leap;
                    n_state  = S_YFWD;
                end else if (r_op == OP_DIFF) begin
                    n_state = S_DIFF;
                end else if (r_op == OP_WEEKDAY) begin
                    n_k     = 5'd20;
                    n_state = S_MOD7;
                end else begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                alu_b   = W_SER'(r_count);
                alu_sub = (r_op == OP_SUB);
                if (r_op == OP_SUB && !alu_ge) begin
                    n_st    = ST_RANGE;
                    n_state = S_OUT;
                end else begin
                    n_ser   = alu_sum;
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                alu_b = (r_op == OP_SUB) ? SER_LO : SER_HI;
                if ((r_op == OP_SUB) ? !alu_ge : alu_ge) begin
                    n_st    = ST_RANGE;
                    n_state = S_OUT;
                end else begin
                    n_yrem  = W_YEAR'(1);
                    n_phase = 2'd0;
                    n_n100  = 2'd0;
                    n_n4    = 5'd0;
                    n_n1    = 2'd0;
                    n_mon   = 4'd1;
                    n_state = S_YREV;
                end
            end
            S_YREV: begin
                if (alu_ge && !cap) begin
                    n_ser  = alu_sum;
                    n_yrem = r_yrem + W_YEAR'(stride_y);
                    if (r_phase == 2'd1) begin
                        n_n100 = r_n100 + 2'd1;
                    end else if (r_phase == 2'd2) begin
                        n_n4 = r_n4 + 5'd1;
                    end else if (r_phase == 2'd3) begin
                        n_n1 = r_n1 + 2'd1;
                    end
                end else if (r_phase == 2'd3) begin
                    n_state = S_MREV;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            S_MREV: begin
                alu_b = W_SER'(month_days(r_mon, rev_leap));
                if (r_mon < 4'd12 && alu_ge) begin
                    n_ser = alu_sum;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_rd    = r_ser[W_DAY-1:0] + W_DAY'(1);
                    n_rm    = r_mon;
                    n_ry    = r_yrem;
                    n_state = S_OUT;
                end
            end
            S_DIFF: begin
                alu_b = r_sa;
                if (!alu_ge) begin
                    n_st = ST_ORDER;
                end else if (alu_sum[W_SER-1:W_NUM] != '0) begin
                    n_st = ST_RANGE;
                end else begin
                    n_rn = alu_sum[W_NUM-1:0];
                end
                n_state = S_OUT;
            end
            S_MOD7: begin
                alu_b   = SEVEN << r_k;
                ser_mod = alu_ge ? alu_sum : r_ser;
                n_ser   = ser_mod;
                if (r_k == 5'd0) begin
                    n_rn    = W_NUM'(ser_mod[2:0]);
                    n_state = S_OUT;
                end else begin
                    n_k = r_k - 5'd1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_phase  <= 2'd0;
            r_n100   <= 2'd0;
            r_n4     <= 5'd0;
            r_n1     <= 2'd0;
            r_k      <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_phase  <= n_phase;
            r_n100   <= n_n100;
            r_n4     <= n_n4;
            r_n1     <= n_n1;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_day_a   <= n_day_a;
        r_month_a <= n_month_a;
        r_year_a  <= n_year_a;
        r_day_b   <= n_day_b;
        r_month_b <= n_month_b;
        r_year_b  <= n_year_b;
        r_count   <= n_count;
        r_mon     <= n_mon;
        r_leap    <= n_leap;
        r_ser     <= n_ser;
        r_sa      <= n_sa;
        r_yrem    <= n_yrem;
        r_va      <= n_va;
        r_rd      <= n_rd;
        r_rm      <= n_rm;
        r_ry      <= n_ry;
        r_rn      <= n_rn;
        r_st      <= n_st;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_OUT);
    assign o_result_day    = r_rd;
    assign o_result_month  = r_rm;
    assign o_result_year   = r_ry;
    assign o_result_number = r_rn;
    assign o_date_valid    = r_va;
    assign o_status        = r_st;

endmodule

>>> rtl/gda_checker.sv
`timescale 1ns / 1ps

module gda_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_done,
    input logic [gda_pkg::W_DAY-1:0]  o_result_day,
    input logic [gda_pkg::W_MON-1:0]  o_result_month,
    input logic [gda_pkg::W_YEAR-1:0] o_result_year,
    input logic [gda_pkg::W_NUM-1:0]  o_result_number,
    input logic                      o_date_valid,
    input logic [gda_pkg::W_ST-1:0]   o_status
);
    import gda_pkg::*;

    // A result only follows a request in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("unit did not return to idle after a result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not make the unit busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
        (o_result_day == '0 && o_result_month == '0 && o_result_year == '0 &&
         o_result_number == '0))
        else $error("error result carries nonzero fields");

    a_bad_date_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_date_valid) |-> (o_status == ST_BAD_DATE))
        else $error("invalid first date without invalid-date status");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);
